// ===== src/cpc_pkg.sv =====
// shared types and constants for the camera parallel capture block
`timescale 1ns / 1ps

package cpc_pkg;

    localparam int CPC_DATA_WIDTH  = 8;
    localparam int CPC_BUS_BITS    = 8;
    localparam int CPC_TIME_BITS   = 32;
    localparam int CPC_LINE_BITS   = 12;
    localparam int CPC_LPIX_BITS   = 16;
    localparam int CPC_TOTAL_BITS  = 24;

    localparam logic [CPC_LINE_BITS-1:0]  CPC_LINE_MAX  = '1;
    localparam logic [CPC_LPIX_BITS-1:0]  CPC_LPIX_MAX  = '1;
    localparam logic [CPC_TOTAL_BITS-1:0] CPC_TOTAL_MAX = '1;

    typedef struct packed {
        logic                     frame_sync;
        logic                     line_valid;
        logic                     pixel_clock;
        logic                     capture_gate;
        logic [CPC_BUS_BITS-1:0]  data_lines;
        logic [CPC_TIME_BITS-1:0] sample_time;
    } t_cap_in;

    typedef struct packed {
        logic                      pixel_valid;
        logic [CPC_BUS_BITS-1:0]   pixel_byte;
        logic                      line_done;
        logic [CPC_LINE_BITS-1:0]  line_index;
        logic [CPC_LPIX_BITS-1:0]  line_pixel_count;
        logic [CPC_TIME_BITS-1:0]  line_duration;
        logic                      frame_skipped;
        logic [CPC_TOTAL_BITS-1:0] pixel_total;
    } t_cap_out;

endpackage

// ===== src/cpc_if.sv =====
// valid/ready channel interfaces for bus samples and capture results
`timescale 1ns / 1ps

interface cpc_in_if import cpc_pkg::*; ();
    logic    valid;
    logic    ready;
    t_cap_in payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface cpc_out_if import cpc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_cap_out payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/camera_parallel_capture.sv =====
// top level: input register, capture core and result register
`timescale 1ns / 1ps

// Parallel camera bus capture. Each request is one sampled snapshot of the
// bus (frame sync, line valid, pixel clock, capture gate, data lines and a
// timestamp) and produces exactly one result: a captured bit-reversed pixel
// byte, a finished-line report with index, pixel count and duration, a
// skipped-frame flag and the running pixel total. A request is taken every
// cycle unless the output side stalls; it is held in the input register,
// passes through the edge and counter logic, and lands in the result
// register. Both registers advance together whenever the result register
// is empty or read.

module camera_parallel_capture import cpc_pkg::*; #(
    parameter int DATA_WIDTH = CPC_DATA_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cpc_in_if.sink    i_in,
    cpc_out_if.source o_out
);

    logic     r_in_valid;
    t_cap_in  r_in_item;
    logic     r_out_valid;
    t_cap_out r_out_item;
    logic     w_advance;
    logic     w_step;
    t_cap_out w_result;

    assign w_advance  = !r_out_valid || o_out.ready;
    assign w_step     = r_in_valid && w_advance;
    assign i_in.ready = !r_in_valid || w_advance;

    cpc_core #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_step),
        .i_item   (r_in_item),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.payload;
        end
        if (w_step) begin
            r_out_item <= w_result;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_item;

endmodule

// ===== src/cpc_core.sv =====
// edge detection, frame/line tracking and pixel capture state
`timescale 1ns / 1ps

module cpc_core import cpc_pkg::*; #(
    parameter int DATA_WIDTH = CPC_DATA_WIDTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_cap_in  i_item,
    output t_cap_out o_result
);

    localparam int RW = (DATA_WIDTH > CPC_BUS_BITS) ? DATA_WIDTH : CPC_BUS_BITS;

    logic                      r_have_prev, n_have_prev;
    logic                      r_prev_fs, r_prev_lv, r_prev_pc;
    logic                      r_frame_active, n_frame_active;
    logic [CPC_LINE_BITS-1:0]  r_line_counter, n_line_counter;
    logic [CPC_LPIX_BITS-1:0]  r_line_pixels, n_line_pixels;
    logic [CPC_TOTAL_BITS-1:0] r_total_pixels, n_total_pixels;
    logic [CPC_TIME_BITS-1:0]  r_line_start, n_line_start;

    logic                      w_act;
    logic                      w_fs_rise, w_fs_fall, w_lv_rise, w_lv_fall, w_pix;
    logic [CPC_LINE_BITS-1:0]  w_line_base;
    logic [CPC_LPIX_BITS-1:0]  w_lpix_base;
    logic [RW-1:0]             w_data_ext;
    logic [RW-1:0]             w_data_rev;

    // reversed data: bit i moves to DATA_WIDTH-1-i, upper bits read as zero
    always_comb begin
        w_data_ext = RW'(i_item.data_lines);
        w_data_rev = '0;
        for (int i = 0; i < DATA_WIDTH; i++) begin
            w_data_rev[DATA_WIDTH-1-i] = w_data_ext[i];
        end
    end

    always_comb begin
        w_act     = r_have_prev && i_item.capture_gate;
        w_fs_rise = w_act && !r_prev_fs && i_item.frame_sync;
        w_fs_fall = w_act && r_prev_fs && !i_item.frame_sync;
        w_lv_rise = w_act && !r_prev_lv && i_item.line_valid;
        w_lv_fall = w_act && r_prev_lv && !i_item.line_valid;

        n_have_prev    = 1'b1;
        n_frame_active = r_frame_active;
        w_line_base    = r_line_counter;
        if (w_fs_rise && (r_total_pixels == '0)) begin
            n_frame_active = 1'b1;
            w_line_base    = '0;
        end
        if (w_fs_fall) begin
            n_frame_active = 1'b0;
        end

        n_line_start = w_lv_rise ? i_item.sample_time : r_line_start;
        w_lpix_base  = w_lv_rise ? '0 : r_line_pixels;

        n_line_counter = w_line_base;
        if (w_lv_fall && (w_line_base != CPC_LINE_MAX)) begin
            n_line_counter = w_line_base + 1'b1;
        end

        w_pix = w_act && n_frame_active && i_item.line_valid &&
                !r_prev_pc && i_item.pixel_clock;

        n_line_pixels  = w_lpix_base;
        n_total_pixels = r_total_pixels;
        if (w_pix) begin
            if (w_lpix_base != CPC_LPIX_MAX) begin
                n_line_pixels = w_lpix_base + 1'b1;
            end
            if (r_total_pixels != CPC_TOTAL_MAX) begin
                n_total_pixels = r_total_pixels + 1'b1;
            end
        end
    end

    always_comb begin
        o_result                  = '0;
        o_result.pixel_valid      = w_pix;
        o_result.pixel_byte       = w_pix ? w_data_rev[CPC_BUS_BITS-1:0] : '0;
        o_result.line_done        = w_lv_fall;
        o_result.line_index       = w_lv_fall ? w_line_base : '0;
        o_result.line_pixel_count = w_lv_fall ? r_line_pixels : '0;
        o_result.line_duration    = w_lv_fall ? (i_item.sample_time - r_line_start) : '0;
        o_result.frame_skipped    = w_fs_rise && (r_total_pixels != '0);
        o_result.pixel_total      = n_total_pixels;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev    <= 1'b0;
            r_prev_fs      <= 1'b0;
            r_prev_lv      <= 1'b0;
            r_prev_pc      <= 1'b0;
            r_frame_active <= 1'b0;
            r_line_counter <= '0;
            r_line_pixels  <= '0;
            r_total_pixels <= '0;
            r_line_start   <= '0;
        end else if (i_en) begin
            r_have_prev    <= n_have_prev;
            r_prev_fs      <= i_item.frame_sync;
            r_prev_lv      <= i_item.line_valid;
            r_prev_pc      <= i_item.pixel_clock;
            r_frame_active <= n_frame_active;
            r_line_counter <= n_line_counter;
            r_line_pixels  <= n_line_pixels;
            r_total_pixels <= n_total_pixels;
            r_line_start   <= n_line_start;
        end
    end

endmodule
